[hw/rtl/greedy_gc_victim_buckets_defines.svh]
// assertion macros shared by the victim bucket block
// expects clk and arst_n in the scope of each use
`ifndef GREEDY_GC_VICTIM_BUCKETS_DEFINES_SVH
`define GREEDY_GC_VICTIM_BUCKETS_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define GGVB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ggvb check failed");

// next-cycle implication, checked out of reset only
`define GGVB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ggvb check failed");

`endif

[hw/rtl/ggvb_pkg.sv]
// shared types and constants for the victim bucket block
// no dependencies
package ggvb_pkg;

	localparam int OPCODE_W = 2;
	localparam int DIE_W    = 2;
	localparam int BLOCK_W  = 10;
	localparam int COUNT_W  = 7;
	localparam int WORD_W   = 64;
	localparam int BIT_W    = 6;

	localparam logic [OPCODE_W-1:0] OP_INVALIDATE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ERASE      = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SELECT     = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [BIT_W-1:0] idx;
	} lsb_res_t;

endpackage

[hw/rtl/ggvb_ram.sv]
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ggvb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ggvb_lsb.sv]
// two-stage lowest-set-bit finder over a 64-bit bitmap word
// depends on ggvb_pkg
module ggvb_lsb
	import ggvb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] word,
	output lsb_res_t          res
);

	logic             v_s1;
	logic [2:0]       grp_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	logic [BIT_W-1:0] idx_s2;
	logic [2:0]       grp;
	logic [2:0]       bidx;

	// lowest non-empty byte
	always_comb begin
		grp = 3'd0;
		for (int g = 7; g >= 0; g--) begin
			if (word[g*8 +: 8] != 8'd0) grp = 3'(g);
		end
	end

	// lowest set bit inside that byte
	always_comb begin
		bidx = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (byte_s1[b]) bidx = 3'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			v_s1     <= start;
			valid_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp;
		byte_s1 <= word[grp*8 +: 8];
		idx_s2  <= {grp_s1, bidx};
	end

	assign res = lsb_res_t'({valid_s2, idx_s2});

endmodule

[hw/rtl/greedy_gc_victim_buckets.sv]
// top level of the greedy gc victim bucket block: sequencer and bucket memories
// depends on ggvb_pkg, ggvb_ram, ggvb_lsb and greedy_gc_victim_buckets_defines.svh
//
// usage: drive opcode, die_index, block_index and invalid_count with start high;
// the item is taken at a clock edge where start is high and busy is low.
// every item gives exactly one result, shown for one cycle with done high on
// victim_found, victim_blk and victim_invalid; the receiver cannot stall.
// an invalidate with a count above one makes two read-modify-write passes
// (the second clears the level just below), any other invalidate or erase
// one, and a rejected item or unknown opcode none. select scans per-level member
// counts from the top level down, one count ram read per cycle, then the
// words of the first non-empty level, then a two-stage lowest-bit search.
// one item is in flight at a time; busy stays high until its result is shown,
// and a new item may be taken in the cycle done is high.
// after reset a clearing pass writes every bitmap word and count to zero, one
// word per cycle, with busy high throughout.
`include "greedy_gc_victim_buckets_defines.svh"

module greedy_gc_victim_buckets
	import ggvb_pkg::*;
#(
	parameter int NUM_DIES        = 4,
	parameter int BLOCKS_PER_DIE  = 1024,
	parameter int PAGES_PER_BLOCK = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [DIE_W-1:0]    die_index,
	input  logic [BLOCK_W-1:0]  block_index,
	input  logic [COUNT_W-1:0]  invalid_count,
	output logic                done,
	output logic                victim_found,
	output logic [BLOCK_W-1:0]  victim_blk,
	output logic [COUNT_W-1:0]  victim_invalid
);

	localparam int WORDS  = (BLOCKS_PER_DIE + WORD_W - 1) / WORD_W;
	localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LEVELS = NUM_DIES * PAGES_PER_BLOCK;
	localparam int DEPTH  = LEVELS * WORDS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CAW    = $clog2(LEVELS);
	localparam int LW     = $clog2(PAGES_PER_BLOCK);
	localparam int CW     = $clog2(BLOCKS_PER_DIE + 1);

	localparam logic [2:0] S_CLEAR     = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_RD        = 3'd2;
	localparam logic [2:0] S_WR        = 3'd3;
	localparam logic [2:0] S_SCAN_LVL  = 3'd4;
	localparam logic [2:0] S_SCAN_WORD = 3'd5;
	localparam logic [2:0] S_LSB       = 3'd6;

	function automatic logic [CAW-1:0] row_of(logic [DIE_W-1:0] d, logic [LW-1:0] l);
		return CAW'(int'(d) * PAGES_PER_BLOCK + int'(l));
	endfunction

	function automatic logic [AW-1:0] addr_of(logic [CAW-1:0] r, logic [WW-1:0] w);
		return AW'(int'(r) * WORDS + int'(w));
	endfunction

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [DIE_W-1:0]   die_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [LW-1:0]      lvl_q;
	logic [LW-1:0]      lvl_d_q;
	logic [WW-1:0]      w_q;
	logic [WW-1:0]      w_d_q;
	logic               set_q;
	logic               second_q;
	logic               rdv_q;
	logic               iss_done_q;

	logic               done_q;
	logic               found_q;
	logic [BLOCK_W-1:0] vblk_q;
	logic [COUNT_W-1:0] vinv_q;

	logic               accept;
	logic               die_ok;
	logic               blk_ok;
	logic               cnt_ok;
	logic [WW-1:0]      wi;
	logic [CAW-1:0]     cur_row;

	logic               bm_we;
	logic [AW-1:0]      bm_waddr;
	logic [WORD_W-1:0]  bm_wdata;
	logic [AW-1:0]      bm_raddr;
	logic [WORD_W-1:0]  bm_rdata;
	logic               ct_we;
	logic [CAW-1:0]     ct_waddr;
	logic [CW-1:0]      ct_wdata;
	logic [CAW-1:0]     ct_raddr;
	logic [CW-1:0]      ct_rdata;

	logic               lsb_start;
	lsb_res_t           lsb_res;

	logic [WORD_W-1:0]  bit_mask;
	logic               old_bit;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign die_ok = int'(die_index) < NUM_DIES;
	assign blk_ok = int'(block_index) < BLOCKS_PER_DIE;
	assign cnt_ok = (invalid_count != '0) && (int'(invalid_count) <= PAGES_PER_BLOCK);

	assign wi       = WW'(blk_q[BLOCK_W-1:BIT_W]);
	assign cur_row  = row_of(die_q, lvl_q);
	assign bit_mask = WORD_W'(1) << blk_q[BIT_W-1:0];
	assign old_bit  = bm_rdata[blk_q[BIT_W-1:0]];

	// memory port steering
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = addr_of(cur_row, wi);
		bm_wdata = set_q ? (bm_rdata | bit_mask) : (bm_rdata & ~bit_mask);
		ct_we    = 1'b0;
		ct_waddr = cur_row;
		ct_wdata = ct_rdata;
		bm_raddr = addr_of(cur_row, wi);
		ct_raddr = cur_row;
		case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q;
				bm_wdata = '0;
				ct_we    = (AW + 1)'(clr_q) < (AW + 1)'(LEVELS);
				ct_waddr = CAW'(clr_q);
				ct_wdata = '0;
			end
			S_WR: begin
				bm_we = 1'b1;
				ct_we = 1'b1;
				// count follows only an actual change of the member bit
				if (set_q && !old_bit) ct_wdata = ct_rdata + CW'(1);
				else if (!set_q && old_bit) ct_wdata = ct_rdata - CW'(1);
				else ct_wdata = ct_rdata;
			end
			S_SCAN_WORD: begin
				bm_raddr = addr_of(cur_row, w_q);
			end
			default: begin
			end
		endcase
	end

	assign lsb_start = (state_q == S_SCAN_WORD) && rdv_q && (bm_rdata != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
					else clr_q <= clr_q + AW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_SELECT && die_ok) begin
							state_q <= S_SCAN_LVL;
						end else if ((opcode == OP_INVALIDATE || opcode == OP_ERASE) &&
								die_ok && blk_ok && cnt_ok) begin
							state_q <= S_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (second_q) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_SCAN_LVL: begin
					if (rdv_q && ct_rdata != '0) begin
						state_q <= S_SCAN_WORD;
					end else if (iss_done_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_SCAN_WORD: begin
					if (lsb_start) begin
						state_q <= S_LSB;
					end else if (iss_done_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_LSB: begin
					if (lsb_res.valid) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				die_q      <= die_index;
				blk_q      <= block_index;
				set_q      <= (opcode == OP_INVALIDATE);
				second_q   <= (opcode == OP_INVALIDATE) && (invalid_count >= COUNT_W'(2));
				rdv_q      <= 1'b0;
				iss_done_q <= 1'b0;
				found_q    <= 1'b0;
				vblk_q     <= '0;
				vinv_q     <= '0;
				if (opcode == OP_SELECT) lvl_q <= LW'(PAGES_PER_BLOCK - 1);
				else lvl_q <= LW'(invalid_count - COUNT_W'(1));
			end
			S_WR: begin
				// second pass of an invalidate clears the level just below
				if (second_q) begin
					second_q <= 1'b0;
					set_q    <= 1'b0;
					lvl_q    <= lvl_q - LW'(1);
				end
			end
			S_SCAN_LVL: begin
				if (rdv_q && ct_rdata != '0) begin
					lvl_q      <= lvl_d_q;
					w_q        <= '0;
					rdv_q      <= 1'b0;
					iss_done_q <= 1'b0;
				end else if (!iss_done_q) begin
					rdv_q   <= 1'b1;
					lvl_d_q <= lvl_q;
					if (lvl_q == '0) iss_done_q <= 1'b1;
					else lvl_q <= lvl_q - LW'(1);
				end
			end
			S_SCAN_WORD: begin
				if (lsb_start) begin
					w_q <= w_d_q;
				end else if (!iss_done_q) begin
					rdv_q <= 1'b1;
					w_d_q <= w_q;
					if (int'(w_q) == WORDS - 1) iss_done_q <= 1'b1;
					else w_q <= w_q + WW'(1);
				end
			end
			S_LSB: begin
				if (lsb_res.valid) begin
					found_q <= 1'b1;
					vblk_q  <= BLOCK_W'({w_q, lsb_res.idx});
					vinv_q  <= COUNT_W'(int'(lvl_q) + 1);
				end
			end
			default: begin
			end
		endcase
	end

	ggvb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	ggvb_ram #(
		.WIDTH(CW),
		.DEPTH(LEVELS)
	) u_count (
		.clk   (clk),
		.we    (ct_we),
		.waddr (ct_waddr),
		.wdata (ct_wdata),
		.raddr (ct_raddr),
		.rdata (ct_rdata)
	);

	ggvb_lsb u_lsb (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lsb_start),
		.word   (bm_rdata),
		.res    (lsb_res)
	);

	assign done           = done_q;
	assign victim_found   = found_q;
	assign victim_blk     = vblk_q;
	assign victim_invalid = vinv_q;

	`GGVB_ASSERT_NOW(a_empty_result_zero, done && !victim_found,
		victim_blk == '0 && victim_invalid == '0)
	`GGVB_ASSERT_NOW(a_found_has_level, done && victim_found, victim_invalid != '0)
	`GGVB_ASSERT_NEXT(a_item_progresses, start && !busy, busy || done)

endmodule
